>>> hw/rtl/swdf_pkg.sv
package swdf_pkg;

  // Number of sequence numbers held in the window.
  localparam int unsigned Window = 64;

  // Width of one sequence number.
  localparam int unsigned SeqW = 64;

  // Width of the fill count, which must also hold Window itself.
  localparam int unsigned FillW = $clog2(Window + 1);

  // Controller states.
  typedef enum logic {
    StIdle,
    StDecide
  } swdf_state_e;

  // Control word broadcast from the controller to every cell.
  typedef struct packed {
    logic compare;  // register a match of the cell's entry against the key
    logic shift;    // take the neighbor's entry, moving the window by one
  } swdf_ctrl_t;

endpackage

>>> hw/rtl/swdf_cell.sv
module swdf_cell
  import swdf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swdf_ctrl_t          ctrl_i,
  input  logic [SeqW-1:0]     key_i,
  input  logic                valid_i,
  input  logic [SeqW-1:0]     entry_i,
  output logic [SeqW-1:0]     entry_o,
  output logic                match_o
);

  logic [SeqW-1:0] entry_q;
  logic            match_q;
  logic            match_d;

  // The entry moves one cell toward the old end of the window on a shift.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      entry_q <= entry_i;
    end
  end

  // A cell only reports a match when it holds a written entry.
  assign match_d = valid_i && (entry_q == key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.compare) begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

>>> hw/rtl/sliding_window_duplicate_filter_unit.sv
// Sliding-window duplicate filter.
//
// A word is a 64-bit sequence number on seq_number_i. It is accepted at a
// rising edge where start is high and busy is low. Each accepted word gives
// exactly one result word: done_o is high for one cycle, and duplicate_o is
// 1 if the number matched one of the last Window accepted distinct numbers
// (the number is then dropped), or 0 if it was new and appended.
//
// The result appears in the cycle after acceptance and is taken at the
// next rising edge. busy is high in that result cycle, so no new word is
// accepted while a result is out: the cells register their compares in the
// accept cycle, and the OR of their match bits decides the shift.
//
// The window is a row of cells; a new number enters cell 0 and each entry
// moves one cell along, the last one falling off when the window is full.
// Reset empties the window through a zero fill count; the entries
// themselves are not cleared. The receiver cannot stall: done_o is a
// single-cycle strobe.
module sliding_window_duplicate_filter_unit
  import swdf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [SeqW-1:0] seq_number_i,
  output logic            done_o,
  output logic            duplicate_o
);

  swdf_state_e      state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [SeqW-1:0]  key_q;
  swdf_ctrl_t       ctrl;
  logic             accept;
  logic             dup;

  logic [Window-1:0]           cell_valid;
  logic [Window-1:0]           cell_match;
  logic [Window-1:0][SeqW-1:0] cell_entry;

  assign accept = start && !busy;
  assign dup    = |cell_match;

  // State and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  // The key is held until the decision so that cell 0 can take it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= seq_number_i;
    end
  end

  // Next state, cell control and the result strobe.
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    busy         = 1'b0;
    done_o       = 1'b0;
    duplicate_o  = 1'b0;
    ctrl.compare = 1'b0;
    ctrl.shift   = 1'b0;
    case (state_q)
      StIdle: begin
        if (start) begin
          ctrl.compare = 1'b1;
          state_d      = StDecide;
        end
      end
      StDecide: begin
        busy        = 1'b1;
        done_o      = 1'b1;
        duplicate_o = dup;
        ctrl.shift  = !dup;
        if (!dup && (fill_q != FillW'(Window))) begin
          fill_d = fill_q + FillW'(1);
        end
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Row of cells: cell 0 holds the newest entry.
  for (genvar i = 0; i < Window; i++) begin : g_cell
    logic [SeqW-1:0] entry_in;

    assign cell_valid[i] = FillW'(i) < fill_q;

    if (i == 0) begin : g_head
      assign entry_in = key_q;
    end else begin : g_body
      assign entry_in = cell_entry[i-1];
    end

    swdf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .key_i   (seq_number_i),
      .valid_i (cell_valid[i]),
      .entry_i (entry_in),
      .entry_o (cell_entry[i]),
      .match_o (cell_match[i])
    );
  end

endmodule

>>> verif/sliding_window_duplicate_filter_unit_test.sv
module sliding_window_duplicate_filter_unit_test;
  import swdf_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned RecentDepth = 2 * Window + 32;
  localparam int unsigned TailCycles = 4;

  // Clock, reset and the ports of the block.
  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [SeqW-1:0] seq_number_i = '0;
  logic            done_o;
  logic            duplicate_o;

  // Shadow copy of the window: oldest number at the front.
  logic [SeqW-1:0] window_model_q[$];
  // Duplicate flags predicted for words that were accepted but not yet answered.
  bit              dup_flag_q[$];
  // Numbers sent lately, reused to provoke hits and hits on evicted entries.
  logic [SeqW-1:0] recent_seq_q[$];
  logic [SeqW-1:0] run_base;

  int unsigned     sender_idle_pct = 0;
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;

  sliding_window_duplicate_filter_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .seq_number_i (seq_number_i),
    .done_o       (done_o),
    .duplicate_o  (duplicate_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // A hung block must not keep the run going forever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Decide whether a number is a duplicate and update the shadow window.
  function automatic bit predict_duplicate(input logic [SeqW-1:0] value);
    foreach (window_model_q[k]) begin
      if (window_model_q[k] == value) begin
        return 1'b1;
      end
    end
    window_model_q = {window_model_q, value};
    if (window_model_q.size() > Window) begin
      window_model_q.delete(0);
    end
    return 1'b0;
  endfunction

  // Offer one word, with random idle cycles before it, and record its prediction.
  task automatic send_word(input logic [SeqW-1:0] value);
    bit was_free;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      seq_number_i <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    start <= 1'b1;
    seq_number_i <= value;
    // busy is sampled at the falling edge, so the accepting rising edge is known.
    do begin
      @(negedge clk_i);
      was_free = !busy;
      @(posedge clk_i);
    end while (!was_free);
    dup_flag_q = {dup_flag_q, predict_duplicate(value)};
    recent_seq_q = {recent_seq_q, value};
    if (recent_seq_q.size() > RecentDepth) begin
      recent_seq_q.delete(0);
    end
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (dup_flag_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Compare every result word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (dup_flag_q.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < MaxReports) begin
          $display("unexpected result word: duplicate=%0b", duplicate_o);
        end
      end else begin
        if (duplicate_o !== dup_flag_q[0]) begin
          error_count <= error_count + 1;
          if (error_count < MaxReports) begin
            $display("duplicate mismatch: expected %0b, actual %0b",
                     dup_flag_q[0], duplicate_o);
          end
        end
        dup_flag_q.delete(0);
      end
    end
  end

  // Empty window: zero is accepted although the store may hold zeros.
  task automatic test_empty_window();
    send_word('0);
    send_word('0);
    send_word('1);
    send_word('1);
    send_word('0);
  endtask

  // Extreme values, exact repeats and near misses, some differing from stored ones in a single bit.
  task automatic test_field_extremes();
    send_word({1'b1, {(SeqW-1){1'b0}}});
    send_word({{(SeqW-1){1'b0}}, 1'b1});
    send_word({1'b0, {(SeqW-1){1'b1}}});
    send_word({{(SeqW-1){1'b1}}, 1'b0});
    send_word({1'b1, {(SeqW-1){1'b0}}});
    send_word({1'b1, {(SeqW-2){1'b0}}, 1'b1});
    send_word({{(SeqW-1){1'b0}}, 1'b1});
    send_word(64'hA5A5_5A5A_F00F_0FF0);
    send_word(64'h5A5A_A5A5_0FF0_F00F);
    send_word(64'hA5A5_5A5A_F00F_0FF0);
    send_word({1'b0, {(SeqW-1){1'b1}}});
    send_word({{(SeqW-1){1'b1}}, 1'b0});
  endtask

  // Full window: the oldest entry falls out and can be accepted again.
  task automatic test_eviction_order();
    logic [SeqW-1:0] base;
    base = {$urandom, $urandom};
    for (int unsigned k = 0; k < Window; k++) begin
      send_word(base + SeqW'(k));
    end
    send_word(base + SeqW'(Window));
    send_word(base);
    send_word(base + SeqW'(Window - 1));
    send_word(base + SeqW'(1));
    send_word(base + SeqW'(2));
  endtask

  // Pick a number: mostly reused or incrementing ones, some noise and extremes.
  function automatic logic [SeqW-1:0] pick_seq();
    int unsigned     sel;
    logic [SeqW-1:0] one_hot;
    sel = $urandom_range(99);
    one_hot = '0;
    one_hot[$urandom_range(SeqW - 1)] = 1'b1;
    if (sel < 40 && recent_seq_q.size() > 0) begin
      return recent_seq_q[$urandom_range(recent_seq_q.size() - 1)];
    end else if (sel < 70) begin
      run_base = run_base + SeqW'($urandom_range(3));
      return run_base;
    end else if (sel < 85) begin
      return {$urandom, $urandom};
    end
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return one_hot;
      default: return ~one_hot;
    endcase
  endfunction

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
    sender_idle_pct = idle_pct;
    run_base = {$urandom, $urandom};
    for (int unsigned n = 0; n < count; n++) begin
      send_word(pick_seq());
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 22;
    test_empty_window();
    test_field_extremes();
    wait_for_drain();
    test_eviction_order();
    wait_for_drain();

    test_random_traffic(22, 520);
    test_random_traffic(72, 520);
    test_random_traffic(0, 520);

    if (dup_flag_q.size() != 0) begin
      error_count = error_count + 1;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
